[sv/snus_pkg.sv]
// Package for the sorted node upsert/split block.
// Holds command and status codes, field widths and the cell control struct.
// No dependencies.
package snus_pkg;

   localparam int CAPACITY_DEF   = 32;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 5;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 3;
   localparam int POS_W   = 6;
   localparam int CNT_W   = 6;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 80;
   localparam int RUN_W   = 4;

   localparam logic [RUN_W-1:0] MAX_RUN = 4'd15;
   localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 6'd32;

   localparam logic [CMD_W-1:0] CMD_UPSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SPLIT  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   localparam logic REG_MAX_ENTRIES = 1'b0;

   typedef struct packed {
      logic compare;
      logic update;
      logic insert;
   } cell_ctrl_type;

endpackage

[sv/snus_cell.sv]
// One entry cell of the sorted node chain: key, value and compare flags.
// Takes its left neighbor's entry on an insert shift. Uses snus_pkg.
module snus_cell #(
   parameter int KEY_BITS   = snus_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = snus_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  snus_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]     cmp_key,
   input  logic [KEY_BITS-1:0]     new_key,
   input  logic [VALUE_BITS-1:0]   new_value,
   input  logic                    occupied,
   input  logic                    prev_lt,
   input  logic [KEY_BITS-1:0]     prev_key,
   input  logic [VALUE_BITS-1:0]   prev_value,
   output logic                    lt,
   output logic                    eq,
   output logic [KEY_BITS-1:0]     key,
   output logic [VALUE_BITS-1:0]   value
);
   import snus_pkg::*;

   logic                  lt_ff;
   logic                  eq_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         lt_ff <= occupied && (key_ff < cmp_key);
         eq_ff <= occupied && (key_ff == cmp_key);
      end
      if (ctrl.update && eq_ff) begin
         value_ff <= new_value;
      end
      if (ctrl.insert) begin
         if (!lt_ff && prev_lt) begin
            key_ff   <= new_key;
            value_ff <= new_value;
         end else if (!prev_lt) begin
            key_ff   <= prev_key;
            value_ff <= prev_value;
         end
      end
   end

   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

[sv/sorted_node_upsert_split.sv]
// Sorted B-tree node with upsert, read and split, built as a chain of entry cells.
// Top level; instantiates snus_cell, uses snus_pkg.
//
// Usage: an item enters on req_ (tuser = command, tdata = key, value, index);
// results leave on rsp_ (tdata = status, position, key, value, entry count;
// tlast marks the final result of an item). The limit max_entries is written
// through the csr_ port at byte address 0, by the user only while the block
// is idle; the block itself does not enforce this. Every cell compares its
// key with the new key on the accept edge; in S_EXEC, once the output register
// is free, the block encodes the insert position and shifts or updates all
// cells at once. Upsert, read and unknown commands give one result, and the
// next item is taken once that result is formed. A split gives its middle key,
// then one moved entry per cycle while the receiver is ready (at most 15), and
// the next item is taken after the last result is formed. One item is in work
// at a time; a new item may be accepted while the last result still waits in
// the output register. A stalled receiver holds the output register and
// freezes the run. Reset empties the node (count zero) and sets max_entries to 32.
module sorted_node_upsert_split #(
   parameter int CAPACITY   = snus_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = snus_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = snus_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [snus_pkg::REQ_W-1:0]    req_tdata,   // key_in, value_in, entry_index
   input  logic [snus_pkg::CMD_W-1:0]    req_tuser,   // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [snus_pkg::RSP_W-1:0]    rsp_tdata,   // status, position, key_out,
                                                      // value_out, entry_count
   output logic                          rsp_tlast,   // last
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import snus_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]      max_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [RUN_W-1:0]      moved_ff, moved_in;

   logic                  rsp_valid_ff;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [KEY_W-1:0]      rsp_key_ff, rsp_key_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  emit;

   logic                  accept;
   logic                  out_free;
   cell_ctrl_type         ctrl;
   logic [KEY_BITS-1:0]   cmp_key;

   logic [CAPACITY-1:0]   occ;
   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic [KEY_BITS-1:0]   cell_key [CAPACITY];
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];

   logic [CW-1:0]         pos;
   logic                  eq_any;
   logic                  full;
   logic [CW-1:0]         mid;
   logic [CW-1:0]         moved_raw;
   logic [IW-1:0]         rd_addr;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmp_key    = KEY_BITS'(req_tdata[31:0]);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_ENTRIES) ? 32'(max_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_MAX_ENTRIES) begin
         max_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occ[i] = (CW'(i) < count_ff);
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == 0) begin : g_head
            snus_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
               .clock(clock), .ctrl(ctrl), .cmp_key(cmp_key),
               .new_key(key_ff), .new_value(value_ff), .occupied(occ[g]),
               .prev_lt(1'b1), .prev_key(key_ff), .prev_value(value_ff),
               .lt(lt_vec[g]), .eq(eq_vec[g]),
               .key(cell_key[g]), .value(cell_value[g])
            );
         end else begin : g_body
            snus_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
               .clock(clock), .ctrl(ctrl), .cmp_key(cmp_key),
               .new_key(key_ff), .new_value(value_ff), .occupied(occ[g]),
               .prev_lt(lt_vec[g-1]), .prev_key(cell_key[g-1]),
               .prev_value(cell_value[g-1]),
               .lt(lt_vec[g]), .eq(eq_vec[g]),
               .key(cell_key[g]), .value(cell_value[g])
            );
         end
      end
   endgenerate

   always_comb begin
      pos = CAP_C;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!lt_vec[i]) begin
            pos = CW'(i);
         end
      end
   end

   assign eq_any    = |eq_vec;
   assign full      = (7'(count_ff) >= 7'(max_ff)) || (count_ff == CAP_C);
   assign mid       = count_ff >> 1;
   assign moved_raw = count_ff - mid - CW'(1);

   always_comb begin
      if (state_ff == S_RUN) begin
         rd_addr = IW'(8'(count_ff) + 8'(run_ff) + 8'd1);
      end else if (cmd_ff == CMD_READ) begin
         rd_addr = IW'(idx_ff);
      end else begin
         rd_addr = IW'(mid);
      end
   end

   always_comb begin
      rd_key   = '0;
      rd_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_addr == IW'(i)) begin
            rd_key   = cell_key[i];
            rd_value = cell_value[i];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      moved_in      = moved_ff;
      emit          = 1'b0;
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      ctrl          = '0;
      ctrl.compare  = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  CMD_UPSERT: begin
                     rsp_pos_in = POS_W'(pos);
                     if (eq_any) begin
                        ctrl.update   = 1'b1;
                        rsp_status_in = ST_UPDATED;
                        rsp_key_in    = KEY_W'(key_ff);
                        rsp_value_in  = VALUE_W'(value_ff);
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.insert  = 1'b1;
                        count_in     = count_ff + CW'(1);
                        rsp_key_in   = KEY_W'(key_ff);
                        rsp_value_in = VALUE_W'(value_ff);
                     end
                  end
                  CMD_READ: begin
                     rsp_pos_in = POS_W'(idx_ff);
                     if (7'(idx_ff) < 7'(count_ff)) begin
                        rsp_key_in   = KEY_W'(rd_key);
                        rsp_value_in = VALUE_W'(rd_value);
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  CMD_SPLIT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in   = mid;
                        rsp_pos_in = POS_W'(mid);
                        rsp_key_in = KEY_W'(rd_key);
                        moved_in   = (8'(moved_raw) > 8'(MAX_RUN)) ? MAX_RUN
                                                                   : RUN_W'(moved_raw);
                        run_in     = '0;
                        if (moved_raw != '0) begin
                           rsp_last_in = 1'b0;
                           state_in    = S_RUN;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_RUN: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_pos_in   = POS_W'(run_ff);
               rsp_key_in   = KEY_W'(rd_key);
               rsp_value_in = VALUE_W'(rd_value);
               rsp_last_in  = (run_ff + RUN_W'(1) == moved_ff);
               run_in       = run_ff + RUN_W'(1);
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         moved_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff   <= run_in;
         moved_ff <= moved_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser;
         key_ff   <= KEY_BITS'(req_tdata[31:0]);
         value_ff <= VALUE_BITS'(req_tdata[63:32]);
         idx_ff   <= req_tdata[68:64];
      end
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // count changes only on an emit, so it stays matched to the held result
   logic [CNT_W-1:0] rsp_count;
   assign rsp_count = CNT_W'(count_ff);

   assign rsp_tdata  = {1'b0, rsp_count, rsp_value_ff, rsp_key_ff, rsp_pos_ff, rsp_status_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[tb/sv/sorted_node_upsert_split_tb.sv]
// Testbench for sorted_node_upsert_split: a mirror of the node predicts every result,
// directed and random upsert/read/split traffic runs under random stalls on both streams.
// Depends on snus_pkg and the sorted_node_upsert_split RTL.
module sorted_node_upsert_split_tb;
   import snus_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN      = 2'd3;
   localparam logic [2:0]       MAX_ENTRIES_ADDR = {REG_MAX_ENTRIES, 2'b00};
   localparam int               CYCLE_LIMIT      = 1_200_000;
   localparam int               SETTLE_CYCLES    = 20;
   localparam int               PHASE_ITEMS      = 45;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [POS_W-1:0]   position;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   count;
      logic               last;
   } node_result_type;

   class node_mirror_type;
      logic [KEY_W-1:0]   keys   [CAPACITY_DEF];
      logic [VALUE_W-1:0] values [CAPACITY_DEF];
      int unsigned        count;
      int unsigned        max_entries;
      int unsigned        failures;
      node_result_type    awaited_results[$];

      function new();
         count       = 0;
         max_entries = MAX_ENTRIES_RESET;
         failures    = 0;
      endfunction

      function int unsigned entry_limit();
         return (max_entries < CAPACITY_DEF) ? max_entries : CAPACITY_DEF;
      endfunction

      function void await_result(logic [STAT_W-1:0] status, int unsigned position,
                                 logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                                 logic last);
         node_result_type r;
         r.status   = status;
         r.position = position[POS_W-1:0];
         r.key      = key;
         r.value    = value;
         r.count    = count[CNT_W-1:0];
         r.last     = last;
         awaited_results.push_back(r);
      endfunction

      function void apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                  logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] idx);
         int unsigned pos;
         int unsigned mid;
         int unsigned moved;
         int unsigned i;
         case (cmd)
            CMD_UPSERT: begin
               pos = 0;
               while (pos < count && keys[pos] < key)
                  pos++;
               if (pos < count && keys[pos] == key) begin
                  values[pos] = value;
                  await_result(ST_UPDATED, pos, key, value, 1'b1);
               end else if (count >= entry_limit()) begin
                  await_result(ST_FULL, pos, '0, '0, 1'b1);
               end else begin
                  for (i = count; i > pos; i--) begin
                     keys[i]   = keys[i-1];
                     values[i] = values[i-1];
                  end
                  keys[pos]   = key;
                  values[pos] = value;
                  count++;
                  await_result(ST_OK, pos, key, value, 1'b1);
               end
            end
            CMD_READ: begin
               if (idx < count)
                  await_result(ST_OK, idx, keys[idx], values[idx], 1'b1);
               else
                  await_result(ST_RANGE, idx, '0, '0, 1'b1);
            end
            CMD_SPLIT: begin
               if (count == 0) begin
                  await_result(ST_EMPTY, 0, '0, '0, 1'b1);
               end else begin
                  mid   = count / 2;
                  moved = count - mid - 1;
                  if (moved > MAX_RUN)
                     moved = MAX_RUN;
                  count = mid;
                  await_result(ST_OK, mid, keys[mid], '0, moved == 0);
                  for (i = 0; i < moved; i++)
                     await_result(ST_OK, i, keys[mid+1+i], values[mid+1+i], i + 1 == moved);
               end
            end
            default: begin
               await_result(ST_OK, 0, '0, '0, 1'b1);
            end
         endcase
      endfunction

      function void check_response(logic [RSP_W-1:0] data, logic last);
         node_result_type got;
         node_result_type exp;
         got.status   = data[2:0];
         got.position = data[8:3];
         got.key      = data[40:9];
         got.value    = data[72:41];
         got.count    = data[78:73];
         got.last     = last;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: st=%0d pos=%0d key=%h val=%h cnt=%0d last=%0b",
                        got.status, got.position, got.key, got.value, got.count, got.last);
            return;
         end
         exp = awaited_results.pop_front();
         if (got !== exp) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected st=%0d pos=%0d key=%h val=%h cnt=%0d last=%0b",
                        exp.status, exp.position, exp.key, exp.value, exp.count, exp.last);
               $display("          actual st=%0d pos=%0d key=%h val=%h cnt=%0d last=%0b",
                        got.status, got.position, got.key, got.value, got.count, got.last);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // key_in, value_in, entry_index
   logic [CMD_W-1:0]    req_tuser;   // command
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // status, position, key_out, value_out, entry_count
   logic                rsp_tlast;   // last
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   node_mirror_type     mirror;
   bit                  steady_flow;
   int unsigned         hold_left;
   int unsigned         cycle_count;

   sorted_node_upsert_split dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25 && mirror.count > 0)
         return mirror.keys[$urandom_range(0, mirror.count - 1)];
      else if (r < 45)
         return KEY_W'($urandom_range(0, 63));
      else if (r < 55)
         return 32'hFFFF_FFC0 | KEY_W'($urandom_range(0, 63));
      else if (r < 62)
         return $urandom_range(0, 1) ? '1 : '0;
      return $urandom();
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady_flow || $urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         hold_left = idle_length() - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_response(rsp_tdata, rsp_tlast);
   end

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                        input logic [VALUE_W-1:0] value, input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, idx, value, key};
      do @(posedge clock); while (!req_tready);
      mirror.apply_request(cmd, key, value, idx);
      gap = (steady_flow || $urandom_range(0, 1)) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_node();
      req_tvalid <= 1'b0;
      while (mirror.awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_max_entries(input int unsigned setting);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_ENTRIES_ADDR;
      csr_pwdata  <= setting;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mirror.max_entries = setting;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_random_traffic(input int unsigned items);
      int unsigned        r;
      int unsigned        top;
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] idx;
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (mirror.count >= mirror.entry_limit() && r < 45)
            cmd = CMD_SPLIT;
         else if (r < 3)
            cmd = CMD_SPLIT;
         else if (r < 6)
            cmd = CMD_UNKNOWN;
         else if (r < 26)
            cmd = CMD_READ;
         else
            cmd = CMD_UPSERT;
         top = (mirror.count < 31) ? mirror.count : 31;
         if (mirror.count > 0 && $urandom_range(0, 9) < 7)
            idx = INDEX_W'($urandom_range(0, top));
         else
            idx = INDEX_W'($urandom_range(0, 31));
         issue(cmd, pick_key(), $urandom(), idx);
      end
   endtask

   initial begin
      int unsigned settings [8];
      int unsigned setting;
      settings    = '{32, 1, 2, 17, 0, 32, 0, 31};
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      steady_flow = 1'b0;
      cycle_count = 0;
      mirror      = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_READ,    '0, '0, 5'd0);
      issue(CMD_READ,    '1, '1, 5'd31);
      issue(CMD_SPLIT,   '0, '0, '0);
      issue(CMD_UNKNOWN, '1, '1, '1);
      issue(CMD_UPSERT,  32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
      issue(CMD_UPSERT,  32'h0000_0000, 32'h0000_0000, 5'd31);
      issue(CMD_UPSERT,  32'hFFFF_FFFF, 32'hA5A5_A5A5, '0);
      issue(CMD_UPSERT,  32'h8000_0000, 32'h1234_5678, '0);
      issue(CMD_UPSERT,  32'h7FFF_FFFF, 32'h5A5A_5A5A, '0);
      issue(CMD_READ,    '0, '0, 5'd3);
      issue(CMD_READ,    '0, '0, 5'd4);
      issue(CMD_UNKNOWN, '0, '0, '0);
      issue(CMD_SPLIT,   '0, '0, '0);
      issue(CMD_SPLIT,   '0, '0, '0);
      issue(CMD_SPLIT,   '0, '0, '0);
      drain_node();

      write_max_entries(1);
      issue(CMD_UPSERT,  32'd5, 32'h0000_0001, '0);
      issue(CMD_UPSERT,  32'd9, 32'h0000_0002, '0);
      issue(CMD_UPSERT,  32'd5, 32'hFFFF_FFFE, '0);
      issue(CMD_UPSERT,  32'd0, 32'h0000_0003, '0);
      issue(CMD_UPSERT,  32'hFFFF_FFFF, 32'h0000_0004, '0);
      issue(CMD_READ,    '0, '0, 5'd0);
      issue(CMD_SPLIT,   '0, '0, '0);
      drain_node();

      foreach (settings[p]) begin
         setting = (settings[p] == 0) ? $urandom_range(1, 32) : settings[p];
         write_max_entries(setting);
         steady_flow = ($urandom_range(0, 3) == 0);
         run_random_traffic(PHASE_ITEMS);
         drain_node();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.failures == 0 && mirror.awaited_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
